// ===== sv/slc_pkg.sv =====
package slc_pkg;

   localparam int DEFAULT_BUFFER_BYTES = 1024;
   localparam int DEFAULT_COUNT_WIDTH  = 24;
   localparam int LINES_W              = 24;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   // one chunk leaving the scanner, plus the end marker of the beat
   typedef struct packed {
      logic fire;
      logic is_end;
      logic chunk_done;
      logic is_comment;
      logic is_code;
   } chunk_event_type;

endpackage

// ===== sv/slc_scan.sv =====
module slc_scan #(
   parameter int BUFFER_BYTES = slc_pkg::DEFAULT_BUFFER_BYTES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic                     op,
   input  logic [7:0]               ch,
   output slc_pkg::chunk_event_type evt
);

   localparam int LEN_W = (BUFFER_BYTES > 2) ? $clog2(BUFFER_BYTES) : 1;
   localparam logic [LEN_W:0] LEN_LAST = (LEN_W + 1)'(BUFFER_BYTES - 1);

   logic             in_block_ff, in_block_in;
   logic             prev_slash_ff, prev_slash_in;
   logic             prev_star_ff, prev_star_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             has_text_ff, has_text_in;
   logic             saw_open_ff, saw_open_in;
   logic             open_first_ff, open_first_in;
   logic             saw_line_ff, saw_line_in;
   logic             saw_close_ff, saw_close_in;

   logic             is_end;
   logic             blank;
   logic             open_hit;
   logic [LEN_W:0]   len_inc;
   logic             done;
   logic             comment;
   logic             e_text, e_open_first, e_line, e_close;

   assign is_end = (op == slc_pkg::OP_END);

   always_comb begin
      case (ch)
         slc_pkg::CH_TAB, slc_pkg::CH_LF, slc_pkg::CH_VT,
         slc_pkg::CH_FF, slc_pkg::CH_CR, slc_pkg::CH_SPACE: blank = 1'b1;
         default: blank = 1'b0;
      endcase
   end

   assign open_hit = (ch == slc_pkg::CH_STAR) && prev_slash_ff;
   assign len_inc  = {1'b0, len_ff} + (LEN_W + 1)'(1);

   always_comb begin
      // on end, classify the partial chunk with the flags as they stand
      if (is_end) begin
         e_text       = has_text_ff;
         e_open_first = open_first_ff;
         e_line       = saw_line_ff;
         e_close      = saw_close_ff;
         done         = (len_ff != '0);
      end else begin
         e_text       = has_text_ff | ~blank;
         e_open_first = open_first_ff | (open_hit & ~saw_open_ff & ~saw_line_ff);
         e_line       = saw_line_ff | ((ch == slc_pkg::CH_SLASH) & prev_slash_ff);
         e_close      = saw_close_ff | ((ch == slc_pkg::CH_SLASH) & prev_star_ff);
         done         = (ch == slc_pkg::CH_LF) || (len_inc == LEN_LAST);
      end
      comment = e_text & (in_block_ff | e_open_first | e_line);
   end

   always_comb begin
      evt.fire       = fire;
      evt.is_end     = is_end;
      evt.chunk_done = done;
      evt.is_comment = comment;
      evt.is_code    = e_text & ~comment;
   end

   always_comb begin
      in_block_in   = in_block_ff;
      prev_slash_in = prev_slash_ff;
      prev_star_in  = prev_star_ff;
      len_in        = len_ff;
      has_text_in   = has_text_ff;
      saw_open_in   = saw_open_ff;
      open_first_in = open_first_ff;
      saw_line_in   = saw_line_ff;
      saw_close_in  = saw_close_ff;
      if (fire) begin
         if (is_end) begin
            in_block_in = 1'b0;
         end else if (done && e_text) begin
            in_block_in = (in_block_ff | e_open_first) & ~e_close;
         end
         if (is_end || done) begin
            prev_slash_in = 1'b0;
            prev_star_in  = 1'b0;
            len_in        = '0;
            has_text_in   = 1'b0;
            saw_open_in   = 1'b0;
            open_first_in = 1'b0;
            saw_line_in   = 1'b0;
            saw_close_in  = 1'b0;
         end else begin
            prev_slash_in = (ch == slc_pkg::CH_SLASH);
            prev_star_in  = (ch == slc_pkg::CH_STAR);
            len_in        = len_inc[LEN_W-1:0];
            has_text_in   = e_text;
            saw_open_in   = saw_open_ff | open_hit;
            open_first_in = e_open_first;
            saw_line_in   = e_line;
            saw_close_in  = e_close;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_block_ff   <= 1'b0;
         prev_slash_ff <= 1'b0;
         prev_star_ff  <= 1'b0;
         len_ff        <= '0;
         has_text_ff   <= 1'b0;
         saw_open_ff   <= 1'b0;
         open_first_ff <= 1'b0;
         saw_line_ff   <= 1'b0;
         saw_close_ff  <= 1'b0;
      end else begin
         in_block_ff   <= in_block_in;
         prev_slash_ff <= prev_slash_in;
         prev_star_ff  <= prev_star_in;
         len_ff        <= len_in;
         has_text_ff   <= has_text_in;
         saw_open_ff   <= saw_open_in;
         open_first_ff <= open_first_in;
         saw_line_ff   <= saw_line_in;
         saw_close_ff  <= saw_close_in;
      end
   end

`ifndef SYNTHESIS
   a_len_below_last: assert property (@(posedge clock) disable iff (reset)
      {1'b0, len_ff} < LEN_LAST)
      else $error("chunk length reached the cut point without closing");

   a_end_clears_block: assert property (@(posedge clock) disable iff (reset)
      (fire && is_end) |=> (!in_block_ff && len_ff == '0 && !has_text_ff))
      else $error("end beat left chunk or block state behind");

   a_markers_imply_text: assert property (@(posedge clock) disable iff (reset)
      (saw_open_ff || saw_line_ff || saw_close_ff) |-> has_text_ff)
      else $error("marker flag set on a chunk with no text");
`endif

endmodule

// ===== sv/slc_tally.sv =====
module slc_tally #(
   parameter int COUNT_WIDTH = slc_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  slc_pkg::chunk_event_type        evt,
   input  logic                            out_stall,
   output logic                            out_busy,
   output logic                            out_valid,
   output logic [slc_pkg::LINES_W-1:0]     out_physical,
   output logic [slc_pkg::LINES_W-1:0]     out_logical,
   output logic [slc_pkg::LINES_W-1:0]     out_comment
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [COUNT_WIDTH-1:0] phys_ff, phys_in, phys_nx;
   logic [COUNT_WIDTH-1:0] code_ff, code_in, code_nx;
   logic [COUNT_WIDTH-1:0] cmt_ff, cmt_in, cmt_nx;
   logic                   valid_ff, valid_in;
   logic [slc_pkg::LINES_W-1:0] phys_out_ff, phys_out_in;
   logic [slc_pkg::LINES_W-1:0] code_out_ff, code_out_in;
   logic [slc_pkg::LINES_W-1:0] cmt_out_ff, cmt_out_in;
   logic                   end_fire;

   // a waiting result only blocks another end beat
   assign out_busy = valid_ff & out_stall;
   assign end_fire = evt.fire & evt.is_end;

   always_comb begin
      phys_nx = phys_ff;
      code_nx = code_ff;
      cmt_nx  = cmt_ff;
      if (evt.chunk_done) begin
         if (phys_ff != COUNT_MAX) phys_nx = phys_ff + COUNT_WIDTH'(1);
         if (evt.is_code && code_ff != COUNT_MAX) code_nx = code_ff + COUNT_WIDTH'(1);
         if (evt.is_comment && cmt_ff != COUNT_MAX) cmt_nx = cmt_ff + COUNT_WIDTH'(1);
      end
   end

   always_comb begin
      phys_in     = phys_ff;
      code_in     = code_ff;
      cmt_in      = cmt_ff;
      phys_out_in = phys_out_ff;
      code_out_in = code_out_ff;
      cmt_out_in  = cmt_out_ff;
      valid_in    = valid_ff & out_stall;
      if (evt.fire) begin
         if (evt.is_end) begin
            phys_in     = '0;
            code_in     = '0;
            cmt_in      = '0;
            phys_out_in = slc_pkg::LINES_W'(phys_nx);
            code_out_in = slc_pkg::LINES_W'(code_nx);
            cmt_out_in  = slc_pkg::LINES_W'(cmt_nx);
            valid_in    = 1'b1;
         end else begin
            phys_in = phys_nx;
            code_in = code_nx;
            cmt_in  = cmt_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phys_ff  <= '0;
         code_ff  <= '0;
         cmt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         phys_ff  <= phys_in;
         code_ff  <= code_in;
         cmt_ff   <= cmt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phys_out_ff <= phys_out_in;
      code_out_ff <= code_out_in;
      cmt_out_ff  <= cmt_out_in;
   end

   assign out_valid    = valid_ff;
   assign out_physical = phys_out_ff;
   assign out_logical  = code_out_ff;
   assign out_comment  = cmt_out_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(end_fire && valid_ff && out_stall))
      else $error("end beat overwrote a result still waiting");

   a_end_clears_counts: assert property (@(posedge clock) disable iff (reset)
      end_fire |=> (phys_ff == '0 && code_ff == '0 && cmt_ff == '0 && valid_ff))
      else $error("end beat did not clear counts or raise result");

   a_counts_grow: assert property (@(posedge clock) disable iff (reset)
      !end_fire |=> (phys_ff >= $past(phys_ff) && code_ff >= $past(code_ff)
                     && cmt_ff >= $past(cmt_ff)))
      else $error("count dropped without an end beat");

   a_split_le_physical: assert property (@(posedge clock) disable iff (reset)
      (code_ff <= phys_ff) && (cmt_ff <= phys_ff))
      else $error("class count exceeds physical count");
`endif

endmodule

// ===== sv/source_line_classifier.sv =====
// A text beat passes the input register, then updates the scanner's line state;
// an end beat passes the input register and the tally result registers to rsp_*.
// Throughput: one beat per cycle, set by the single input register feeding the
// scanner and counters; a stalled result holds an end beat, and all input behind it.
// Reset (synchronous, active high) clears all line state, counts and valid flags.
module source_line_classifier #(
   parameter int BUFFER_BYTES = slc_pkg::DEFAULT_BUFFER_BYTES,
   parameter int COUNT_WIDTH  = slc_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [7:0]                      req_ch,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [slc_pkg::LINES_W-1:0]     rsp_physical_lines,
   output logic [slc_pkg::LINES_W-1:0]     rsp_logical_lines,
   output logic [slc_pkg::LINES_W-1:0]     rsp_commented_lines
);

   logic                     in_valid_ff, in_valid_in;
   logic                     in_op_ff, in_op_in;
   logic [7:0]               in_ch_ff, in_ch_in;
   logic                     out_busy;
   logic                     go;
   logic                     load;
   slc_pkg::chunk_event_type evt;

   // hold an end beat while the previous result is still stalled
   assign go        = in_valid_ff & ~((in_op_ff == slc_pkg::OP_END) & out_busy);
   assign req_stall = in_valid_ff & ~go;
   assign load      = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = load | (in_valid_ff & ~go);
      in_op_in    = load ? req_op : in_op_ff;
      in_ch_in    = load ? req_ch : in_ch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_op_ff <= in_op_in;
      in_ch_ff <= in_ch_in;
   end

   slc_scan #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .fire (go),
      .op   (in_op_ff),
      .ch   (in_ch_ff),
      .evt  (evt)
   );

   slc_tally #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_tally (
      .clock       (clock),
      .reset       (reset),
      .evt         (evt),
      .out_stall   (rsp_stall),
      .out_busy    (out_busy),
      .out_valid   (rsp_valid),
      .out_physical(rsp_physical_lines),
      .out_logical (rsp_logical_lines),
      .out_comment (rsp_commented_lines)
   );

endmodule
